// ----- rtl/core/chme_pkg.sv -----
`default_nettype none
package chme_pkg;

  typedef enum logic [1:0] {
    CMD_GET    = 2'd0,
    CMD_PUT    = 2'd1,
    CMD_REMOVE = 2'd2,
    CMD_SPARE  = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_FULL     = 2'd1,
    ST_ZERO_KEY = 2'd2,
    ST_SPARE    = 2'd3
  } status_t;

  localparam int unsigned FIELD_BITS = 32;
  localparam int unsigned COUNT_BITS = 11;

  typedef struct packed {
    logic [1:0]            command;
    logic [FIELD_BITS-1:0] key;
    logic [FIELD_BITS-1:0] value;
  } in_req_t;

  typedef struct packed {
    logic                  hit;
    logic [FIELD_BITS-1:0] found_value;
    logic [COUNT_BITS-1:0] entry_count;
    logic [1:0]            status;
  } out_req_t;

endpackage
`default_nettype wire

// ----- rtl/core/chme_front.sv -----
`default_nettype none
// Front end: masks the key, screens zero keys and works out the bucket
// index by reciprocal multiplication with one correcting subtract, then
// hands a classified request to the queue.
module chme_front #(
  parameter int unsigned BUCKET_COUNT = 509,
  parameter int unsigned KEY_BITS     = 32,
  parameter int unsigned BW           = 9
) (
  input  wire                       clk,
  input  wire                       rst_n,
  input  wire                       in_push,
  output logic                      in_full,
  input  wire chme_pkg::in_req_t    in_data,
  output logic                      q_push,
  input  wire                       q_full,
  output logic [1:0]                q_cmd,
  output logic [KEY_BITS-1:0]       q_key,
  output logic [31:0]               q_value,
  output logic [BW-1:0]             q_bucket,
  output logic                      q_zero
);
  import chme_pkg::*;

  localparam int unsigned SB = (KEY_BITS > 32) ? 32 : KEY_BITS;
  localparam int unsigned SH = SB + BW;
  localparam int unsigned PW = 2 * SB + 1;
  // With this reciprocal the quotient estimate is exact or one short, so the
  // first remainder is below twice the bucket count.
  localparam logic [SB:0] RECIP = (SB+1)'((64'd1 << SH) / 64'(BUCKET_COUNT));

  typedef enum logic [2:0] {S_IDLE, S_MUL, S_SUB, S_FIX, S_OUT} fstate_t;

  fstate_t state_r;
  logic [1:0] cmd_r;
  logic [KEY_BITS-1:0] key_r;
  logic [31:0] val_r;
  logic [PW-1:0] prod_r;
  logic [BW:0] rem_r;
  logic [SB-1:0] shk;
  logic [SB-1:0] quo;
  logic [SB-1:0] quo_b;

  assign shk   = SB'(key_r >> 2);
  assign quo   = SB'(prod_r >> SH);
  assign quo_b = quo * SB'(BUCKET_COUNT);
  assign in_full = (state_r != S_IDLE);
  assign q_push  = (state_r == S_OUT) && !q_full;
  assign q_cmd    = cmd_r;
  assign q_key    = key_r;
  assign q_value  = val_r;
  assign q_bucket = rem_r[BW-1:0];
  assign q_zero   = (key_r == '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      case (state_r)
        S_IDLE: begin
          if (in_push) begin
            cmd_r   <= in_data.command;
            key_r   <= KEY_BITS'(in_data.key);
            val_r   <= in_data.value;
            state_r <= S_MUL;
          end
        end
        S_MUL: begin
          prod_r  <= PW'(shk) * PW'(RECIP);
          state_r <= S_SUB;
        end
        S_SUB: begin
          rem_r   <= (BW+1)'(shk - quo_b);
          state_r <= S_FIX;
        end
        S_FIX: begin
          if (rem_r >= (BW+1)'(BUCKET_COUNT)) begin
            rem_r <= rem_r - (BW+1)'(BUCKET_COUNT);
          end
          state_r <= S_OUT;
        end
        S_OUT: begin
          if (!q_full) begin
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

// ----- rtl/core/chme_queue.sv -----
`default_nettype none
// Two-entry queue between front and back ends.
module chme_queue #(
  parameter int unsigned W = 8
) (
  input  wire          clk,
  input  wire          rst_n,
  input  wire          push,
  output logic         full,
  input  wire [W-1:0]  wdata,
  input  wire          pop,
  output logic         empty,
  output logic [W-1:0] rdata
);
  logic [W-1:0] mem_r [2];
  logic wp_r, rp_r;
  logic [1:0] cnt_r;

  assign full  = (cnt_r == 2'd2);
  assign empty = (cnt_r == 2'd0);
  assign rdata = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= '0;
    end else begin
      if (push && !full) begin
        mem_r[wp_r] <= wdata;
        wp_r <= ~wp_r;
      end
      if (pop && !empty) begin
        rp_r <= ~rp_r;
      end
      cnt_r <= cnt_r + 2'((push && !full) ? 1 : 0) - 2'((pop && !empty) ? 1 : 0);
    end
  end
endmodule
`default_nettype wire

// ----- rtl/core/chme_back.sv -----
`default_nettype none
// Back end: clears the bucket heads and loads the free stack after reset,
// then walks a chain per request through the node memories and applies
// the command.
module chme_back #(
  parameter int unsigned BUCKET_COUNT = 509,
  parameter int unsigned NODE_POOL    = 1024,
  parameter int unsigned KEY_BITS     = 32,
  parameter int unsigned BW           = 9,
  parameter int unsigned NW           = 11
) (
  input  wire                      clk,
  input  wire                      rst_n,
  input  wire                      q_empty,
  output logic                     q_pop,
  input  wire [1:0]                q_cmd,
  input  wire [KEY_BITS-1:0]       q_key,
  input  wire [31:0]               q_value,
  input  wire [BW-1:0]             q_bucket,
  input  wire                      q_zero,
  output logic                     out_empty,
  input  wire                      out_pop,
  output chme_pkg::out_req_t       out_data,
  output logic                     busy_clear
);
  import chme_pkg::*;

  localparam int unsigned IW = NW - 1;
  localparam logic [NW-1:0] NIL = NW'(NODE_POOL);
  localparam int unsigned CLR_N = (NODE_POOL > BUCKET_COUNT) ? NODE_POOL : BUCKET_COUNT;
  localparam int unsigned CLW = $clog2(CLR_N + 1);

  typedef enum logic [3:0] {
    S_CLR, S_IDLE, S_HEAD, S_HEADW, S_RD, S_RDW, S_CMP, S_FREE, S_FREEW,
    S_ACT, S_OUT
  } bstate_t;

  logic [NW-1:0]       head_mem [BUCKET_COUNT];
  logic [KEY_BITS-1:0] key_mem  [NODE_POOL];
  logic [31:0]         val_mem  [NODE_POOL];
  logic [NW-1:0]       link_mem [NODE_POOL];
  logic [IW-1:0]       free_mem [NODE_POOL];

  bstate_t state_r;
  logic [CLW-1:0] clr_r;
  logic [NW-1:0] free_top_r, count_r;
  logic [NW-1:0] cur_r, prev_r, head_q_r, link_q_r, steps_r;
  logic [KEY_BITS-1:0] key_q_r;
  logic [31:0] val_q_r;
  logic [IW-1:0] free_q_r;
  logic [1:0] cmd_r;
  logic [KEY_BITS-1:0] key_r;
  logic [31:0] value_r;
  logic [BW-1:0] bkt_r;
  logic hit_r, full_r;
  logic [31:0] found_r;
  logic [1:0] status_r;
  logic [NW-1:0] rd_idx_r;

  assign busy_clear = (state_r == S_CLR);
  assign q_pop = (state_r == S_IDLE) && !q_empty;
  assign out_empty = (state_r != S_OUT);
  assign out_data.hit = hit_r;
  assign out_data.found_value = found_r;
  assign out_data.entry_count = COUNT_BITS'(count_r);
  assign out_data.status = status_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_CLR;
      clr_r      <= '0;
      free_top_r <= NIL;
      count_r    <= '0;
    end else begin
      case (state_r)
        S_CLR: begin
          // The free stack starts with node zero on top.
          if (clr_r < CLW'(BUCKET_COUNT)) head_mem[clr_r[BW-1:0]] <= NIL;
          if (clr_r < CLW'(NODE_POOL)) begin
            free_mem[clr_r[IW-1:0]] <= IW'(NODE_POOL - 1) - clr_r[IW-1:0];
          end
          clr_r <= clr_r + 1'b1;
          if (clr_r == CLW'(CLR_N - 1)) state_r <= S_IDLE;
        end
        S_IDLE: begin
          if (!q_empty) begin
            cmd_r    <= q_cmd;
            key_r    <= q_key;
            value_r  <= q_value;
            bkt_r    <= q_bucket;
            hit_r    <= 1'b0;
            found_r  <= '0;
            prev_r   <= NIL;
            steps_r  <= '0;
            if (q_zero) begin
              status_r <= ST_ZERO_KEY;
              state_r  <= S_OUT;
            end else begin
              status_r <= ST_OK;
              state_r  <= S_HEAD;
            end
          end
        end
        S_HEAD: begin
          head_q_r <= head_mem[bkt_r];
          state_r  <= S_HEADW;
        end
        S_HEADW: begin
          cur_r   <= head_q_r;
          state_r <= (head_q_r >= NIL) ? S_FREE : S_RD;
        end
        S_RD: begin
          rd_idx_r <= cur_r;
          key_q_r  <= key_mem[cur_r[IW-1:0]];
          val_q_r  <= val_mem[cur_r[IW-1:0]];
          link_q_r <= link_mem[cur_r[IW-1:0]];
          state_r  <= S_CMP;
        end
        S_CMP: begin
          if (key_q_r == key_r) begin
            hit_r   <= 1'b1;
            found_r <= val_q_r;
            state_r <= S_ACT;
          end else begin
            prev_r  <= rd_idx_r;
            steps_r <= steps_r + 1'b1;
            if (link_q_r >= NIL || steps_r == NW'(NODE_POOL - 1)) begin
              state_r <= S_FREE;
            end else begin
              cur_r   <= link_q_r;
              state_r <= S_RD;
            end
          end
        end
        S_FREE: begin
          // Miss: fetch the top of the free stack in case this is an insert.
          prev_r  <= NIL;
          full_r  <= (free_top_r == '0) || (free_top_r > NIL);
          free_q_r <= free_mem[free_top_r[IW-1:0] - 1'b1];
          state_r <= S_FREEW;
        end
        S_FREEW: begin
          if (cmd_r == CMD_PUT) begin
            if (full_r) begin
              status_r <= ST_FULL;
            end else begin
              free_top_r <= free_top_r - 1'b1;
              key_mem[free_q_r]  <= key_r;
              val_mem[free_q_r]  <= value_r;
              link_mem[free_q_r] <= head_q_r;
              head_mem[bkt_r]    <= NW'(free_q_r);
              count_r <= count_r + 1'b1;
            end
          end
          state_r <= S_OUT;
        end
        S_ACT: begin
          if (cmd_r == CMD_PUT) begin
            val_mem[rd_idx_r[IW-1:0]] <= value_r;
          end else if (cmd_r == CMD_REMOVE) begin
            if (prev_r < NIL) link_mem[prev_r[IW-1:0]] <= link_q_r;
            else head_mem[bkt_r] <= link_q_r;
            if (free_top_r < NIL) begin
              free_mem[free_top_r[IW-1:0]] <= rd_idx_r[IW-1:0];
              free_top_r <= free_top_r + 1'b1;
            end
            if (count_r != '0) count_r <= count_r - 1'b1;
          end
          state_r <= S_OUT;
        end
        S_OUT: begin
          if (out_pop) state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

// ----- rtl/core/chained_hash_map_engine_unit.sv -----
`default_nettype none
// Channel  | Ports                        | Direction
// in       | in_push, in_full, in_data    | request in (command, key, value)
// out      | out_empty, out_pop, out_data | result out (hit, value, count, status)
//
// The front end takes one request at a time through accept, reciprocal multiply,
// subtract, correcting subtract and hand-off to the queue. The back end reads
// the bucket head, then reads and compares each chain node visited; a miss also
// reads the free stack, a zero key goes straight to the result, and each result
// waits for out_pop. After reset the back end clears bucket heads and loads the
// free stack; the front end still takes requests, which wait in the queue.
// Reset is synchronous, active low. Either side may stall independently.
module chained_hash_map_engine_unit #(
  parameter int unsigned BUCKET_COUNT = 509,
  parameter int unsigned NODE_POOL    = 1024,
  parameter int unsigned KEY_BITS     = 32
) (
  input  wire                    clk,
  input  wire                    rst_n,
  input  wire                    in_push,
  output logic                   in_full,
  input  wire chme_pkg::in_req_t in_data,
  output logic                   out_empty,
  input  wire                    out_pop,
  output chme_pkg::out_req_t     out_data
);
  import chme_pkg::*;

  localparam int unsigned BW = $clog2(BUCKET_COUNT);
  localparam int unsigned NW = $clog2(NODE_POOL) + 1;
  localparam int unsigned QW = 2 + KEY_BITS + 32 + BW + 1;

  logic fq_push, fq_full, bq_pop, bq_empty, busy_clear;
  logic [1:0] f_cmd;
  logic [KEY_BITS-1:0] f_key;
  logic [31:0] f_val;
  logic [BW-1:0] f_bkt;
  logic f_zero;
  logic [QW-1:0] q_rd;

  chme_front #(.BUCKET_COUNT(BUCKET_COUNT), .KEY_BITS(KEY_BITS), .BW(BW)) u_front (
    .clk, .rst_n, .in_push, .in_full, .in_data,
    .q_push(fq_push), .q_full(fq_full), .q_cmd(f_cmd), .q_key(f_key),
    .q_value(f_val), .q_bucket(f_bkt), .q_zero(f_zero)
  );

  chme_queue #(.W(QW)) u_queue (
    .clk, .rst_n, .push(fq_push), .full(fq_full),
    .wdata({f_cmd, f_key, f_val, f_bkt, f_zero}),
    .pop(bq_pop), .empty(bq_empty), .rdata(q_rd)
  );

  chme_back #(.BUCKET_COUNT(BUCKET_COUNT), .NODE_POOL(NODE_POOL),
              .KEY_BITS(KEY_BITS), .BW(BW), .NW(NW)) u_back (
    .clk, .rst_n, .q_empty(bq_empty), .q_pop(bq_pop),
    .q_cmd(q_rd[QW-1 -: 2]), .q_key(q_rd[QW-3 -: KEY_BITS]),
    .q_value(q_rd[BW+32 -: 32]), .q_bucket(q_rd[BW:1]), .q_zero(q_rd[0]),
    .out_empty, .out_pop, .out_data, .busy_clear
  );

  a_no_out_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    busy_clear |-> out_empty) else $error("result during bucket clear");
  a_zero_key: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_data.status == ST_ZERO_KEY) |-> !out_data.hit)
    else $error("zero key reported a hit");
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty |-> out_data.entry_count <= COUNT_BITS'(NODE_POOL))
    else $error("entry count beyond pool");
endmodule
`default_nettype wire

// ----- sim/tb.sv -----
`timescale 1ns / 100ps
module tb;
  import chme_pkg::*;

  localparam int BUCKETS = 509;
  localparam int POOL    = 1024;
  localparam int NIL     = POOL;
  localparam int N_RAND  = 100;
  localparam int N_DRAIN = 64;

  logic     clk;
  logic     rst_n;
  logic     in_push;
  logic     in_full;
  in_req_t  in_data;
  logic     out_empty;
  logic     out_pop;
  out_req_t out_data;

  chained_hash_map_engine_unit dut (
    .clk(clk), .rst_n(rst_n),
    .in_push(in_push), .in_full(in_full), .in_data(in_data),
    .out_empty(out_empty), .out_pop(out_pop), .out_data(out_data)
  );

  // Shadow copy of the map.
  int unsigned head_of[BUCKETS];
  logic [31:0] nkey[POOL];
  logic [31:0] nval[POOL];
  int unsigned nlink[POOL];
  int unsigned free_list[POOL];
  int unsigned free_cnt;
  int unsigned live_cnt;

  out_req_t pending[$];
  int       errors;
  int       n_sent;
  int       n_got;
  int       n_full;
  int       n_hit;
  bit       quiet;
  logic [31:0] used_keys[$];

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #50ms;
    $display("timeout at %0t", $time);
    $display("FAILURE");
    $finish;
  end

  task automatic map_reset();
    for (int i = 0; i < BUCKETS; i++) head_of[i] = NIL;
    for (int i = 0; i < POOL; i++) begin
      nkey[i] = '0;
      nval[i] = '0;
      nlink[i] = NIL;
      free_list[i] = POOL - 1 - i;
    end
    free_cnt = POOL;
    live_cnt = 0;
  endtask

  function automatic out_req_t map_apply(in_req_t rq);
    out_req_t    r;
    int unsigned b, p, prv, prior, n, m;
    r = '0;
    r.status = ST_OK;
    if (rq.key == 0) begin
      r.status = ST_ZERO_KEY;
    end else begin
      b = (rq.key >> 2) % BUCKETS;
      p = head_of[b];
      prior = NIL;
      n = NIL;
      prv = NIL;
      for (int s = 0; s < POOL && p < NIL; s++) begin
        if (nkey[p] == rq.key) begin
          n = p;
          prv = prior;
          break;
        end
        prior = p;
        p = nlink[p];
      end
      if (n < NIL) begin
        r.hit = 1'b1;
        r.found_value = nval[n];
      end
      if (rq.command == CMD_PUT) begin
        if (n < NIL) nval[n] = rq.value;
        else if (free_cnt == 0) r.status = ST_FULL;
        else begin
          free_cnt--;
          m = free_list[free_cnt];
          nkey[m] = rq.key;
          nval[m] = rq.value;
          nlink[m] = head_of[b];
          head_of[b] = m;
          live_cnt++;
        end
      end else if (rq.command == CMD_REMOVE && n < NIL) begin
        if (prv < NIL) nlink[prv] = nlink[n];
        else head_of[b] = nlink[n];
        free_list[free_cnt] = n;
        free_cnt++;
        live_cnt--;
      end
    end
    r.entry_count = live_cnt[10:0];
    return r;
  endfunction

  // Pushes one request and records its expected result; fixed_ok selects a typed result.
  task automatic send_req(in_req_t rq, bit fixed_ok, out_req_t fixed);
    out_req_t pr;
    if (!quiet && $urandom_range(0, 5) == 0) begin
      in_push <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
    in_push <= 1'b1;
    in_data <= rq;
    @(posedge clk);
    while (in_full) @(posedge clk);
    pr = map_apply(rq);
    if (fixed_ok && pr != fixed) begin
      $display("%0t table row mismatch: expected %h predicted %h", $time, fixed, pr);
      errors++;
    end
    pending.push_back(fixed_ok ? fixed : pr);
    if (pr.status == ST_FULL) n_full++;
    if (pr.hit) n_hit++;
    n_sent++;
  endtask

  // Result side: random pop stalls, checked against the oldest expectation.
  initial begin
    out_req_t e;
    int       stall;
    out_pop = 1'b0;
    stall = 0;
    forever begin
      @(posedge clk);
      if (rst_n && out_pop && !out_empty) begin
        if (pending.size() == 0) begin
          $display("%0t unexpected result %h", $time, out_data);
          errors++;
        end else begin
          e = pending.pop_front();
          if (out_data.hit !== e.hit)
            $display("%0t hit: expected %0d actual %0d", $time, e.hit, out_data.hit);
          if (out_data.found_value !== e.found_value)
            $display("%0t found_value: expected %h actual %h", $time,
                     e.found_value, out_data.found_value);
          if (out_data.entry_count !== e.entry_count)
            $display("%0t entry_count: expected %0d actual %0d", $time,
                     e.entry_count, out_data.entry_count);
          if (out_data.status !== e.status)
            $display("%0t status: expected %0d actual %0d", $time, e.status, out_data.status);
          if (out_data !== e) errors++;
          n_got++;
        end
      end
      if (stall > 0) begin
        stall--;
        out_pop <= 1'b0;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        stall = $urandom_range(1, 17) - 1;
        out_pop <= 1'b0;
      end else begin
        out_pop <= 1'b1;
      end
    end
  end

  function automatic out_req_t mk_res(logic h, logic [31:0] v, int c, status_t s);
    out_req_t r;
    r.hit = h;
    r.found_value = v;
    r.entry_count = c[10:0];
    r.status = s;
    return r;
  endfunction

  function automatic logic [31:0] pick_key();
    int k;
    k = $urandom_range(0, 9);
    if (used_keys.size() > 0 && k < 6) return used_keys[$urandom_range(0, used_keys.size() - 1)];
    // Many keys share a bucket when they differ by a multiple of the bucket span.
    if (k < 8) return 32'(($urandom_range(1, 40) * BUCKETS * 4) + $urandom_range(0, 3));
    return $urandom();
  endfunction

  typedef struct {
    in_req_t  rq;
    bit       typed;
    out_req_t res;
  } row_t;

  initial begin
    row_t     rows[$];
    in_req_t  rq;
    logic [31:0] k;
    int       wait_n;
    errors = 0; n_sent = 0; n_got = 0; n_full = 0; n_hit = 0;
    quiet = 1'b0;
    rst_n = 1'b0;
    in_push = 1'b0;
    in_data = '0;
    map_reset();
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    rows.push_back('{'{CMD_GET, 32'h0000_0001, 32'h0}, 1, mk_res(0, 0, 0, ST_OK)});
    rows.push_back('{'{CMD_PUT, 32'h0, 32'hFFFF_FFFF}, 1, mk_res(0, 0, 0, ST_ZERO_KEY)});
    rows.push_back('{'{CMD_GET, 32'h0, 32'h0}, 1, mk_res(0, 0, 0, ST_ZERO_KEY)});
    rows.push_back('{'{CMD_REMOVE, 32'h0, 32'h0}, 1, mk_res(0, 0, 0, ST_ZERO_KEY)});
    rows.push_back('{'{CMD_SPARE, 32'h0, 32'h0}, 1, mk_res(0, 0, 0, ST_ZERO_KEY)});
    rows.push_back('{'{CMD_PUT, 32'hFFFF_FFFF, 32'hFFFF_FFFF}, 1, mk_res(0, 0, 1, ST_OK)});
    rows.push_back('{'{CMD_GET, 32'hFFFF_FFFF, 32'h0}, 1, mk_res(1, 32'hFFFF_FFFF, 1, ST_OK)});
    rows.push_back('{'{CMD_PUT, 32'hFFFF_FFFF, 32'h0}, 1, mk_res(1, 32'hFFFF_FFFF, 1, ST_OK)});
    rows.push_back('{'{CMD_PUT, 32'h0000_0001, 32'hA5A5_5A5A}, 0, '0});
    rows.push_back('{'{CMD_PUT, 32'h0000_0002, 32'h1}, 0, '0});
    rows.push_back('{'{CMD_PUT, 32'h0000_07F5, 32'h2}, 0, '0});
    rows.push_back('{'{CMD_PUT, 32'h0000_0FE9, 32'h3}, 0, '0});
    rows.push_back('{'{CMD_SPARE, 32'h0000_07F5, 32'h0}, 0, '0});
    rows.push_back('{'{CMD_REMOVE, 32'h0000_07F5, 32'h0}, 0, '0});
    rows.push_back('{'{CMD_GET, 32'h0000_0FE9, 32'h0}, 0, '0});
    rows.push_back('{'{CMD_REMOVE, 32'h0000_0002, 32'h0}, 0, '0});
    rows.push_back('{'{CMD_REMOVE, 32'h0000_0002, 32'h0}, 0, '0});
    rows.push_back('{'{CMD_REMOVE, 32'h0000_0FE9, 32'h0}, 0, '0});
    rows.push_back('{'{CMD_REMOVE, 32'hFFFF_FFFF, 32'h0}, 0, '0});
    rows.push_back('{'{CMD_REMOVE, 32'h0000_0001, 32'h0}, 0, '0});
    foreach (rows[i]) send_req(rows[i].rq, rows[i].typed, rows[i].res);

    // Fill the pool, then exercise puts into the full pool and drain part of it.
    for (int i = 0; i < POOL; i++) begin
      k = 32'(i * 4 + 16) ^ (i[0] ? 32'h8000_0000 : 32'h0);
      rq.command = CMD_PUT;
      rq.key = k;
      rq.value = $urandom();
      send_req(rq, 0, '0);
      used_keys.push_back(k);
    end
    for (int i = 0; i < 8; i++) begin
      rq.command = CMD_PUT;
      rq.key = $urandom() | 32'h4000_0003;
      rq.value = $urandom();
      send_req(rq, 0, '0);
    end
    rq.command = CMD_PUT;
    rq.key = used_keys[5];
    rq.value = 32'h1234_5678;
    send_req(rq, 0, '0);
    for (int i = 0; i < N_DRAIN; i++) begin
      rq.command = CMD_REMOVE;
      rq.key = used_keys[i];
      rq.value = $urandom();
      send_req(rq, 0, '0);
    end
    used_keys.delete();

    for (int i = 0; i < N_RAND; i++) begin
      if (i >= N_RAND - 40) quiet = 1'b1;
      k = pick_key();
      if ($urandom_range(0, 49) == 0) k = '0;
      rq.command = cmd_t'($urandom_range(0, 9) < 4 ? CMD_PUT : $urandom_range(0, 3));
      rq.key = k;
      rq.value = $urandom();
      if (rq.command == CMD_PUT && k != 0 && used_keys.size() < 200) used_keys.push_back(k);
      send_req(rq, 0, '0);
    end
    in_push <= 1'b0;

    wait_n = 0;
    while (pending.size() != 0 && wait_n < 200000) begin
      @(posedge clk);
      wait_n++;
    end
    repeat (200) @(posedge clk);
    if (pending.size() != 0) begin
      $display("%0d results never arrived", pending.size());
      errors++;
    end
    $display("Sent %0d requests, checked %0d results (%0d hits, %0d pool-full rejects).",
             n_sent, n_got, n_hit, n_full);
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end
endmodule
